/* src/mlfq_pkg.sv */
// Package with the shared constants, types and control structs of the MLFQ picker.
`timescale 1ns / 1ps
package mlfq_pkg;
  localparam int LEVELS      = 4;
  localparam int THREADS     = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TH_W   = $clog2(THREADS);
  localparam int POS_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W = 2;
  localparam int TIME_W = 16;
  localparam int ENT_W  = TH_W + PRIO_W;
  localparam int TMEM_D = THREADS * LEVELS;
  localparam int TMEM_W = $clog2(TMEM_D);
  localparam int EMEM_D = LEVELS * QUEUE_DEPTH;
  localparam int EMEM_W = $clog2(EMEM_D);

  localparam logic       CMD_ADD    = 1'b0;
  localparam logic [1:0] ST_PICKED  = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_ADDED   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // clear one time memory word after reset
    logic load;       // capture input beat, reset current level
    logic do_add;     // append captured thread at level 0
    logic scan_start; // start head search at current level
    logic scan_step;  // examine one entry of current level
    logic next_level; // advance current level
    logic shift_step; // move one entry down over the removed slot
    logic shift_start;
    logic append_next;// append removed head to next level
    logic time_write; // write back updated time
    logic res_pick;
    logic res_empty;
    logic res_full;
    logic res_added;
  } mlfq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic is_add;
    logic full;
    logic level_empty;
    logic last_level;
    logic scan_done;
    logic shift_done;
    logic demote;     // head must move down
  } mlfq_stat_t;
endpackage

/* src/mlfq_if.sv */
// Valid/ready channel interfaces for the MLFQ picker.
`timescale 1ns / 1ps
interface mlfq_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] thread_id;
  logic [1:0] thread_priority;
  modport source (output valid, cmd, thread_id, thread_priority, input ready);
  modport sink   (input valid, cmd, thread_id, thread_priority, output ready);
endinterface

interface mlfq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] chosen_thread;
  logic [1:0] chosen_level;
  logic [3:0] slice_ticks;
  modport source (output valid, status, chosen_thread, chosen_level, slice_ticks,
                  input ready);
  modport sink   (input valid, status, chosen_thread, chosen_level, slice_ticks,
                  output ready);
endinterface

/* src/mlfq_datapath.sv */
// Datapath of the MLFQ picker: queue memory, counts, time memory and result.
`timescale 1ns / 1ps
module mlfq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mlfq_pkg::mlfq_cmd_t          cmd,
  output mlfq_pkg::mlfq_stat_t         stat,
  input  logic                         in_cmd,
  input  logic [3:0]                   in_thread,
  input  logic [1:0]                   in_prio,
  output logic [1:0]                   status,
  output logic [3:0]                   chosen_thread,
  output logic [1:0]                   chosen_level,
  output logic [3:0]                   slice_ticks
);
  localparam int TH_W  = mlfq_pkg::TH_W;
  localparam int POS_W = mlfq_pkg::POS_W;
  localparam int CNT_W = mlfq_pkg::CNT_W;
  localparam int LVL_W = mlfq_pkg::LVL_W;
  localparam int ENT_W = mlfq_pkg::ENT_W;
  localparam int TW    = mlfq_pkg::TIME_W;
  localparam int EW    = mlfq_pkg::EMEM_W;
  localparam int TMW   = mlfq_pkg::TMEM_W;

  logic [ENT_W-1:0]  emem [mlfq_pkg::EMEM_D];
  logic [TW-1:0]     tmem [mlfq_pkg::TMEM_D];
  logic [CNT_W-1:0]  counts [mlfq_pkg::LEVELS];
  logic [CNT_W-1:0]  total;

  logic              op;
  logic [TH_W-1:0]   new_th;
  logic [1:0]        new_prio;
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  lvl_up;
  logic [CNT_W-1:0]  idx;       // scan / shift pointer
  logic [POS_W-1:0]  best;
  logic [1:0]        best_prio;
  logic [ENT_W-1:0]  head;
  logic [ENT_W-1:0]  rd;        // registered memory read
  logic [TW-1:0]     t_rd;
  logic [TW:0]       t_sum;
  logic [TW-1:0]     slice;
  logic [POS_W-1:0]  rd_pos;
  logic              rd_ok;

  logic [EW-1:0]     e_raddr;
  logic [EW-1:0]     e_waddr;
  logic              e_we;
  logic [ENT_W-1:0]  e_wdata;
  logic [TMW-1:0]    t_addr;
  logic [TMW-1:0]    t_waddr;
  logic [TMW-1:0]    clr_idx;
  logic              t_we;
  logic [TW-1:0]     t_wdata;

  function automatic logic [mlfq_pkg::EMEM_W-1:0] ea(input logic [LVL_W-1:0] l,
                                                     input logic [POS_W-1:0] p);
    ea = mlfq_pkg::EMEM_W'(l * mlfq_pkg::QUEUE_DEPTH + p);
  endfunction

  assign lvl_up = lvl + 1'b1;
  assign slice  = TW'(1) << lvl;
  assign t_sum  = {1'b0, t_rd} + {1'b0, slice};
  assign t_addr = TMW'(head[ENT_W-1:2] * mlfq_pkg::LEVELS + lvl);

  // One read port: entry 0 when a scan starts, the entry after the removed
  // slot when compaction starts, two ahead while compacting, else the scan
  // pointer. Read data is registered in rd.
  always_comb begin
    if (cmd.scan_start)       e_raddr = ea(lvl, '0);
    else if (cmd.shift_start) e_raddr = ea(lvl, best + 1'b1);
    else if (cmd.shift_step)  e_raddr = ea(lvl, idx[POS_W-1:0] + 2'd2);
    else                      e_raddr = ea(lvl, idx[POS_W-1:0]);
  end

  // One write port shared by add, move to the next level and compaction.
  always_comb begin
    e_we    = 1'b0;
    e_waddr = '0;
    e_wdata = '0;
    if (cmd.do_add) begin
      e_we    = 1'b1;
      e_waddr = ea('0, counts[0][POS_W-1:0]);
      e_wdata = {new_th, new_prio};
    end else if (cmd.append_next) begin
      e_we    = 1'b1;
      e_waddr = ea(lvl_up, counts[lvl_up][POS_W-1:0]);
      e_wdata = head;
    end else if (cmd.shift_step && !stat.shift_done) begin
      e_we    = 1'b1;
      e_waddr = ea(lvl, idx[POS_W-1:0]);
      e_wdata = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    rd <= emem[e_raddr];
  end

  assign t_we    = cmd.clr_step || cmd.time_write;
  assign t_waddr = cmd.clr_step ? clr_idx : t_addr;
  assign t_wdata = cmd.clr_step ? '0 : (t_sum[TW] ? {TW{1'b1}} : t_sum[TW-1:0]);

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_waddr] <= t_wdata;
    t_rd <= tmem[t_addr];
  end

  always_comb begin
    total = '0;
    for (int l = 0; l < mlfq_pkg::LEVELS; l++) total = total + counts[l];
  end

  assign stat.clr_done    = (clr_idx == TMW'(mlfq_pkg::TMEM_D - 1));
  assign stat.is_add      = (op == mlfq_pkg::CMD_ADD);
  assign stat.full        = (total >= CNT_W'(mlfq_pkg::QUEUE_DEPTH));
  assign stat.level_empty = (counts[lvl] == '0);
  assign stat.last_level  = (lvl == LVL_W'(mlfq_pkg::LEVELS - 1));
  assign stat.scan_done   = (idx >= counts[lvl]) && !rd_ok;
  assign stat.shift_done  = (CNT_W'(idx) + 1'b1 >= counts[lvl]);
  assign stat.demote      = (t_rd >= slice) && !stat.last_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) counts[l] <= '0;
      rd_ok   <= 1'b0;
      clr_idx <= '0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.load) begin
        op       <= in_cmd;
        new_th   <= in_thread[TH_W-1:0];
        new_prio <= in_prio;
        lvl      <= '0;
      end
      if (cmd.do_add) counts[0] <= counts[0] + 1'b1;
      if (cmd.next_level) lvl <= lvl + 1'b1;
      if (cmd.scan_start || (cmd.scan_step && (idx < counts[lvl]))) rd_ok <= 1'b1;
      else rd_ok <= 1'b0;
      if (cmd.scan_start) begin
        idx <= CNT_W'(1);
        rd_pos <= '0;
        best_prio <= 2'd3;
        best <= '0;
        head <= '0;
      end
      if (cmd.scan_step) begin
        if (rd_ok && ((rd_pos == '0) || (rd[1:0] < best_prio))) begin
          best <= rd_pos;
          best_prio <= rd[1:0];
          head <= rd;
        end
        if (idx < counts[lvl]) begin
          rd_pos <= idx[POS_W-1:0];
          idx <= idx + 1'b1;
        end
      end
      if (cmd.shift_start) idx <= CNT_W'(best);
      if (cmd.shift_step) begin
        idx <= idx + 1'b1;
        if (stat.shift_done) counts[lvl] <= counts[lvl] - 1'b1;
      end
      if (cmd.append_next) counts[lvl_up] <= counts[lvl_up] + 1'b1;
      if (cmd.res_pick) begin
        status        <= mlfq_pkg::ST_PICKED;
        chosen_thread <= 4'(head[ENT_W-1:2]);
        chosen_level  <= 2'(lvl);
        slice_ticks   <= slice[3:0];
      end
      if (cmd.res_empty || cmd.res_full || cmd.res_added) begin
        status        <= cmd.res_empty ? mlfq_pkg::ST_EMPTY :
                         cmd.res_full ? mlfq_pkg::ST_FULL : mlfq_pkg::ST_ADDED;
        chosen_thread <= '0;
        chosen_level  <= '0;
        slice_ticks   <= '0;
      end
    end
  end
endmodule

/* src/mlfq_ctrl.sv */
// Controller state machine of the MLFQ picker.
`timescale 1ns / 1ps
module mlfq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  mlfq_pkg::mlfq_stat_t  stat,
  output mlfq_pkg::mlfq_cmd_t   cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_LVL   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_TREQ  = 4'd4;
  localparam logic [3:0] S_TCHK  = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;

  logic [3:0] state, state_next;
  logic       demoting, demoting_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    demoting_next = demoting;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.is_add) begin
          if (stat.full) cmd.res_full = 1'b1;
          else begin
            cmd.do_add = 1'b1;
            cmd.res_added = 1'b1;
          end
          state_next = S_OUT;
        end else state_next = S_LVL;
      end
      S_LVL: begin
        if (!stat.level_empty) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else if (stat.last_level) begin
          cmd.res_empty = 1'b1;
          state_next = S_OUT;
        end else cmd.next_level = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.scan_step = 1'b0;
          state_next = S_TREQ;
        end
      end
      S_TREQ: state_next = S_TCHK;
      S_TCHK: begin
        cmd.shift_start = 1'b1;
        demoting_next = stat.demote;
        if (stat.demote) cmd.append_next = 1'b1;
        else begin
          cmd.time_write = 1'b1;
          cmd.res_pick = 1'b1;
        end
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) state_next = demoting ? S_LVL : S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      demoting <= 1'b0;
    end else begin
      state <= state_next;
      demoting <= demoting_next;
    end
  end
endmodule

/* src/multilevel_feedback_queue_picker_unit.sv */
// Top level of the multilevel feedback queue picker.
//
//   Channel  Dir  Beat content
//   in       in   cmd, thread_id, thread_priority
//   out      out  status, chosen_thread, chosen_level, slice_ticks
//
// An add is accepted, decoded and answered with the output beat. A pick is
// accepted and decoded, then visits the levels in order until one holds
// entries, scans every entry of that level for the head, looks up the head's
// time and compacts the level; every move of a head to the next level repeats
// this at the same level. The output beat then follows.
// After reset the time store is cleared one word per cycle, all
// THREADS*LEVELS words, during which no input beat is accepted. One item is in
// flight at a time and the result register holds while the output beat is
// stalled.
`timescale 1ns / 1ps
module multilevel_feedback_queue_picker_unit (
  input  logic         clk,
  input  logic         rst,
  mlfq_in_if.sink      in,
  mlfq_out_if.source   out
);
  mlfq_pkg::mlfq_cmd_t  cmd;
  mlfq_pkg::mlfq_stat_t stat;

  mlfq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .stat(stat), .cmd(cmd)
  );

  mlfq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_cmd(in.cmd), .in_thread(in.thread_id), .in_prio(in.thread_priority),
    .status(out.status), .chosen_thread(out.chosen_thread),
    .chosen_level(out.chosen_level), .slice_ticks(out.slice_ticks)
  );
endmodule
